// ===== hw/rtl/rsort_pkg.sv =====
// ----------------------------------------------------------------------------
// rsort_pkg
// Shared types and constants for the record insertion sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package rsort_pkg;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned NVAL     = 5;
  localparam int unsigned NEXT     = 3;
  localparam int unsigned DATE_W   = 31;
  localparam int unsigned TYPE_W   = 8;
  localparam int unsigned VAL_W    = 64;

  typedef struct packed {
    logic [DATE_W-1:0]           key;
    logic [TYPE_W-1:0]           rtype;
    logic [NVAL-1:0][VAL_W-1:0]  vals;
    logic [NEXT-1:0][DATE_W-1:0] extras;
  } record_t;

  // what a cell shows its neighbors
  typedef struct packed {
    record_t rec;
    logic    valid;
    logic    gt;     // holds a key greater than the incoming one
  } link_t;

  typedef struct packed {
    logic ins;       // insert the incoming record this cycle
    logic shl;       // drain: take the next cell's contents
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rsort_cell.sv =====
// ----------------------------------------------------------------------------
// rsort_cell
// One slot of the sorting chain: compares, shifts right on insert,
// shifts left on drain.
// ----------------------------------------------------------------------------
`default_nettype none

module rsort_cell (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  rsort_pkg::cell_ctrl_t ctrl_i,
  input  rsort_pkg::record_t   new_rec_i,
  input  rsort_pkg::link_t     prev_i,
  input  rsort_pkg::link_t     next_i,
  output rsort_pkg::link_t     link_o
);
  import rsort_pkg::*;

  record_t rec_q, rec_d;
  logic    valid_q, valid_d;
  logic    gt;
  logic    take_prev, take_new;

  assign gt        = valid_q && (rec_q.key > new_rec_i.key);
  assign take_prev = prev_i.gt;
  assign take_new  = !take_prev && (gt || (!valid_q && prev_i.valid));

  always_comb begin
    rec_d   = rec_q;
    valid_d = valid_q;
    priority if (ctrl_i.shl) begin
      rec_d   = next_i.rec;
      valid_d = next_i.valid;
    end else if (ctrl_i.ins && take_prev) begin
      rec_d   = prev_i.rec;
      valid_d = 1'b1;
    end else if (ctrl_i.ins && take_new) begin
      rec_d   = new_rec_i;
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign link_o.rec   = rec_q;
  assign link_o.valid = valid_q;
  assign link_o.gt    = gt;

endmodule

`default_nettype wire

// ===== hw/rtl/record_insertion_sorter_top.sv =====
// ----------------------------------------------------------------------------
// record_insertion_sorter_top
// Stable insertion sorter on a chain of CAPACITY cells.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  input     start / busy              date_key_i .. last_record_i
//  result    result_valid_o (strobe)   out_key_o .. overflowed_o
//
//  All cells compare an incoming record in parallel.
//  After a last record, the chain drains one record per cycle from cell 0,
//  with busy high throughout.
//  A record arriving at a full chain is dropped and flags overflow.
//  Reset clears the cell valid bits and flags; no clearing pass.
//  The receiver cannot stall: each result shows for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module record_insertion_sorter_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start,
  output logic        busy,
  input  wire  [30:0] date_key_i,
  input  wire  [7:0]  type_code_i,
  input  wire  [63:0] value_a_i,
  input  wire  [63:0] value_b_i,
  input  wire  [63:0] value_c_i,
  input  wire  [63:0] value_d_i,
  input  wire  [63:0] value_e_i,
  input  wire  [30:0] extra_date_a_i,
  input  wire  [30:0] extra_date_b_i,
  input  wire  [30:0] extra_date_c_i,
  input  wire         last_record_i,
  output logic        result_valid_o,
  output logic [30:0] out_key_o,
  output logic [7:0]  out_type_o,
  output logic [63:0] out_value_a_o,
  output logic [63:0] out_value_b_o,
  output logic [63:0] out_value_c_o,
  output logic [63:0] out_value_d_o,
  output logic [63:0] out_value_e_o,
  output logic [30:0] out_extra_a_o,
  output logic [30:0] out_extra_b_o,
  output logic [30:0] out_extra_c_o,
  output logic        run_end_o,
  output logic        overflowed_o
);
  import rsort_pkg::*;

  link_t      lnk [CAPACITY];
  link_t      head_link, tail_link;
  record_t    new_rec;
  cell_ctrl_t ctrl;
  logic       accept, full;
  logic       drain_q, drain_d;
  logic       drop_q, drop_d;

  assign new_rec.key       = date_key_i;
  assign new_rec.rtype     = type_code_i;
  assign new_rec.vals[0]   = value_a_i;
  assign new_rec.vals[1]   = value_b_i;
  assign new_rec.vals[2]   = value_c_i;
  assign new_rec.vals[3]   = value_d_i;
  assign new_rec.vals[4]   = value_e_i;
  assign new_rec.extras[0] = extra_date_a_i;
  assign new_rec.extras[1] = extra_date_b_i;
  assign new_rec.extras[2] = extra_date_c_i;

  assign busy   = drain_q;
  assign accept = start && !drain_q;
  assign full   = lnk[CAPACITY-1].valid;

  assign ctrl.ins = accept && !full;
  assign ctrl.shl = drain_q;

  // cell 0 sees an always-valid, never-greater left neighbor
  assign head_link.rec   = new_rec;
  assign head_link.valid = 1'b1;
  assign head_link.gt    = 1'b0;
  assign tail_link.rec   = new_rec;
  assign tail_link.valid = 1'b0;
  assign tail_link.gt    = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      rsort_cell u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .ctrl_i    (ctrl),
        .new_rec_i (new_rec),
        .prev_i    (head_link),
        .next_i    (lnk[i+1]),
        .link_o    (lnk[i])
      );
    end else if (i == CAPACITY - 1) begin : g_last
      rsort_cell u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .ctrl_i    (ctrl),
        .new_rec_i (new_rec),
        .prev_i    (lnk[i-1]),
        .next_i    (tail_link),
        .link_o    (lnk[i])
      );
    end else begin : g_mid
      rsort_cell u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .ctrl_i    (ctrl),
        .new_rec_i (new_rec),
        .prev_i    (lnk[i-1]),
        .next_i    (lnk[i+1]),
        .link_o    (lnk[i])
      );
    end
  end

  assign run_end_o = drain_q && !lnk[1].valid;

  always_comb begin
    drain_d = drain_q;
    drop_d  = drop_q;
    if (accept && full) begin
      drop_d = 1'b1;
    end
    if (accept && last_record_i) begin
      drain_d = 1'b1;
    end
    if (run_end_o) begin
      drain_d = 1'b0;
      drop_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q <= 1'b0;
      drop_q  <= 1'b0;
    end else begin
      drain_q <= drain_d;
      drop_q  <= drop_d;
    end
  end

  assign result_valid_o = drain_q;
  assign out_key_o      = lnk[0].rec.key;
  assign out_type_o     = lnk[0].rec.rtype;
  assign out_value_a_o  = lnk[0].rec.vals[0];
  assign out_value_b_o  = lnk[0].rec.vals[1];
  assign out_value_c_o  = lnk[0].rec.vals[2];
  assign out_value_d_o  = lnk[0].rec.vals[3];
  assign out_value_e_o  = lnk[0].rec.vals[4];
  assign out_extra_a_o  = lnk[0].rec.extras[0];
  assign out_extra_b_o  = lnk[0].rec.extras[1];
  assign out_extra_c_o  = lnk[0].rec.extras[2];
  assign overflowed_o   = drop_q;

endmodule

`default_nettype wire
